// ===== design/hcbd_pkg.sv =====
`default_nettype none

package hcbd_pkg;

    // Default width of the chunk size and of the payload byte counter.
    localparam int SIZE_WIDTH_DEF = 32;

    // Default number of entries in the queue between front and back end.
    localparam int QUEUE_DEPTH_DEF = 4;

    // Characters of the chunk-size line.
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    // Number of bytes skipped after each chunk's payload.
    localparam logic [1:0] SKIP_COUNT = 2'd2;

    // Body status codes.
    localparam logic [1:0] ST_IN_PROGRESS = 2'd0;
    localparam logic [1:0] ST_COMPLETE    = 2'd1;
    localparam logic [1:0] ST_INCOMPLETE  = 2'd2;

    // One received body byte.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       final_byte;
    } in_item_t;

    // One decoder result.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic [1:0] body_status;
    } out_item_t;

    // A received byte after classification by the front end.
    typedef struct packed {
        logic [7:0] ch;
        logic       final_byte;
        logic       is_hex;
        logic [3:0] hex_val;
        logic       is_cr;
        logic       is_lf;
    } cls_item_t;

    // Decoder phases.
    typedef enum logic [5:0] {
        PH_LINE    = 6'b000001,
        PH_LINE_CR = 6'b000010,
        PH_DATA    = 6'b000100,
        PH_SKIP    = 6'b001000,
        PH_DONE    = 6'b010000,
        PH_ENDED   = 6'b100000
    } phase_t;

endpackage

`default_nettype wire

// ===== design/hcbd_front.sv =====
`default_nettype none

module hcbd_front
    import hcbd_pkg::*;
(
    input  wire logic      body_valid,
    output logic           body_stall,
    input  wire in_item_t  body_item,
    input  wire logic      queue_full,
    output logic           push,
    output cls_item_t      push_item
);

    // Returns {is_hex, value} for one character.
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    logic [4:0] hex_res;

    // Accept an item whenever the queue has room.
    assign body_stall = queue_full;
    assign push       = body_valid && !queue_full;

    // Classify the byte so the back end only sees flags.
    assign hex_res = hex_decode(body_item.in_byte);

    always_comb
    begin
        push_item.ch         = body_item.in_byte;
        push_item.final_byte = body_item.final_byte;
        push_item.is_hex     = hex_res[4];
        push_item.hex_val    = hex_res[3:0];
        push_item.is_cr      = (body_item.in_byte == CHAR_CR);
        push_item.is_lf      = (body_item.in_byte == CHAR_LF);
    end

endmodule

`default_nettype wire

// ===== design/hcbd_queue.sv =====
`default_nettype none

module hcbd_queue
    import hcbd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire cls_item_t push_item,
    output logic           full,
    input  wire logic      pop,
    output cls_item_t      head_item,
    output logic           empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cls_item_t          mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign head_item = mem_reg[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ===== design/hcbd_back.sv =====
`default_nettype none

module hcbd_back
    import hcbd_pkg::*;
#(
    parameter int SIZE_WIDTH = SIZE_WIDTH_DEF
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      queue_empty,
    input  wire cls_item_t head_item,
    output logic           pop,
    output logic           result_valid,
    input  wire logic      result_stall,
    output out_item_t      result_item
);

    phase_t                 phase_reg, phase_next;
    logic [SIZE_WIDTH-1:0]  accum_reg, accum_next;
    logic                   stopped_reg, stopped_next;
    logic [SIZE_WIDTH-1:0]  left_reg, left_next;
    logic [1:0]             skip_reg, skip_next;
    logic                   res_valid_reg;
    out_item_t              res_item_reg;

    logic                   out_free;
    logic                   active;
    logic                   emit;
    logic                   pass_byte;
    logic [1:0]             status;
    logic                   sat;
    logic [SIZE_WIDTH-1:0]  shifted;

    // The output register frees when empty or when its item is taken.
    assign out_free     = !res_valid_reg || !result_stall;
    assign pop          = !queue_empty && out_free;
    assign active       = pop && (phase_reg != PH_DONE) && (phase_reg != PH_ENDED);
    assign result_valid = res_valid_reg;
    assign result_item  = res_item_reg;

    // Saturating size accumulation: overflow shows in the top hex digit.
    assign sat     = (accum_reg[SIZE_WIDTH-1 -: 4] != 4'd0);
    assign shifted = {accum_reg[SIZE_WIDTH-5:0], head_item.hex_val};

    // Chunk decoding state machine, one item per cycle while the queue is not empty and the output register is free.
    always_comb
    begin
        phase_next   = phase_reg;
        accum_next   = accum_reg;
        stopped_next = stopped_reg;
        left_next    = left_reg;
        skip_next    = skip_reg;
        emit         = 1'b0;
        pass_byte    = 1'b0;
        status       = ST_IN_PROGRESS;
        if (active) begin
            unique case (phase_reg)
                PH_LINE:
                begin
                    if (head_item.is_cr) begin
                        phase_next = PH_LINE_CR;
                    end else if (!stopped_reg && head_item.is_hex) begin
                        accum_next = sat ? '1 : shifted;
                    end else begin
                        stopped_next = 1'b1;
                    end
                end
                PH_LINE_CR:
                begin
                    if (head_item.is_lf) begin
                        if (accum_reg == '0) begin
                            phase_next = PH_DONE;
                            status     = ST_COMPLETE;
                            emit       = 1'b1;
                        end else begin
                            left_next  = accum_reg;
                            phase_next = PH_DATA;
                        end
                        accum_next   = '0;
                        stopped_next = 1'b0;
                    end else begin
                        // A lone CR belongs to the line and stops the digits.
                        stopped_next = 1'b1;
                        if (!head_item.is_cr) begin
                            phase_next = PH_LINE;
                        end
                    end
                end
                PH_DATA:
                begin
                    pass_byte = 1'b1;
                    emit      = 1'b1;
                    left_next = left_reg - 1'b1;
                    if (left_reg == SIZE_WIDTH'(1)) begin
                        skip_next  = SKIP_COUNT;
                        phase_next = PH_SKIP;
                    end
                end
                PH_SKIP:
                begin
                    skip_next = skip_reg - 1'b1;
                    if (skip_reg == 2'd1) begin
                        phase_next = PH_LINE;
                    end
                end
                default:
                begin
                end
            endcase
            // The last byte before close ends the body unless it completed it.
            if (head_item.final_byte && phase_next != PH_DONE) begin
                phase_next = PH_ENDED;
                status     = ST_INCOMPLETE;
                emit       = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg     <= PH_LINE;
            accum_reg     <= '0;
            stopped_reg   <= 1'b0;
            left_reg      <= '0;
            skip_reg      <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            accum_reg   <= accum_next;
            stopped_reg <= stopped_next;
            left_reg    <= left_next;
            skip_reg    <= skip_next;
            if (out_free) begin
                res_valid_reg <= emit;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (out_free && emit) begin
            res_item_reg.out_byte    <= pass_byte ? head_item.ch : 8'd0;
            res_item_reg.byte_valid  <= pass_byte;
            res_item_reg.body_status <= status;
        end
    end

endmodule

`default_nettype wire

// ===== design/http_chunked_body_decoder.sv =====
// A byte is written into the queue, and its result is then registered in the back end.
// Throughput: one byte per cycle unless results are stalled and the queue fills.
// The input stalls only when the queue (four entries by default) is full because results are stalled.
// Reset clears the phase, size and counters, the queue and the output valid flag;
// payload registers are not reset and there is no clearing pass.
`default_nettype none

module http_chunked_body_decoder
    import hcbd_pkg::*;
#(
    parameter int SIZE_WIDTH  = SIZE_WIDTH_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      body_valid,
    output logic           body_stall,
    input  wire in_item_t  body_item,
    output logic           result_valid,
    input  wire logic      result_stall,
    output out_item_t      result_item
);

    logic      q_push;
    cls_item_t q_push_item;
    logic      q_full;
    logic      q_pop;
    cls_item_t q_head_item;
    logic      q_empty;

    // Front end: accepts and classifies bytes.
    hcbd_front u_front (
        .body_valid (body_valid),
        .body_stall (body_stall),
        .body_item  (body_item),
        .queue_full (q_full),
        .push       (q_push),
        .push_item  (q_push_item)
    );

    // Queue decoupling the two ends.
    hcbd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_push_item),
        .full      (q_full),
        .pop       (q_pop),
        .head_item (q_head_item),
        .empty     (q_empty)
    );

    // Back end: chunk decoding and result register.
    hcbd_back #(
        .SIZE_WIDTH (SIZE_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .queue_empty  (q_empty),
        .head_item    (q_head_item),
        .pop          (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

endmodule

`default_nettype wire

// ===== design/hcbd_checker.sv =====
`default_nettype none

module hcbd_checker
    import hcbd_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      body_valid,
    input wire logic      body_stall,
    input wire in_item_t  body_item,
    input wire logic      result_valid,
    input wire logic      result_stall,
    input wire out_item_t result_item
);

    // A stalled input item holds until taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        body_valid && body_stall |=> body_valid && $stable(body_item))
    else $error("stalled input item changed");

    // A stalled result holds until taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result_item))
    else $error("stalled result changed");

    // Once an end status is delivered no further result appears next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && result_item.body_status != ST_IN_PROGRESS
        |=> !result_valid)
    else $error("result after end of body");

    // A result in progress always carries a payload byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_item.body_status == ST_IN_PROGRESS
        |-> result_item.byte_valid)
    else $error("empty result while in progress");

    // A status-only result carries a zero byte and a defined end status.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_item.byte_valid
        |-> result_item.out_byte == 8'd0
            && (result_item.body_status == ST_COMPLETE
                || result_item.body_status == ST_INCOMPLETE))
    else $error("bad status-only result");

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .body_valid   (body_valid),
    .body_stall   (body_stall),
    .body_item    (body_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
);

`default_nettype wire
